// File: design/assert_macros.svh
// Assertion macros used by keypad_code_lock_core.
// Standalone header, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define KCL_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define KCL_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/kcl_pkg.sv
// Types and constants for the keypad code lock.
// No dependencies; used by kcl_ctrl and keypad_code_lock_core.
package kcl_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_ENTER    = 2'd1,
        MODE_UNLOCKED = 2'd2,
        MODE_CHANGE   = 2'd3
    } mode_t;

    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_DIGIT  = 3'd1;
    localparam logic [2:0] FUNC_CLEAR  = 3'd2;
    localparam logic [2:0] FUNC_CHANGE = 3'd3;
    localparam logic [2:0] FUNC_OPEN   = 3'd4;

    localparam logic [7:0] TIMEOUT_RESET = 8'd100;
    localparam logic [7:0] TICK_MAX      = 8'hff;
    localparam logic [7:0] TICK_STEP     = 8'h01;
    localparam logic [3:0] RESET_DIGIT   = 4'd8;
    localparam logic [3:0] DIGIT_MAX     = 4'd9;

    typedef struct packed {
        mode_t      mode;
        logic       relay;
        logic       error;
        logic [2:0] digits;
    } lock_status_t;

endpackage

// File: design/kcl_ctrl.sv
// Lock state registers and single-pass next-state logic for one word.
// Depends on kcl_pkg.
module kcl_ctrl #(
    parameter int CODE_LEN = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [2:0]           func,
    input  logic [3:0]           digit,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_data,
    output kcl_pkg::lock_status_t status_next
);
    import kcl_pkg::*;

    localparam int CNT_W = $clog2(CODE_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_LEN);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       tick_reg, tick_next;
    logic             err_reg, err_next;
    logic [7:0]       timeout_reg;
    logic [3:0]       entry_reg [CODE_LEN];
    logic [3:0]       entry_next [CODE_LEN];
    logic [3:0]       code_reg [CODE_LEN];
    logic [3:0]       code_next [CODE_LEN];
    logic             match;
    logic [CNT_W+2:0] cnt_ext;

    always_comb begin
        match = 1'b1;
        for (int k = 0; k < CODE_LEN; k++) begin
            if (entry_reg[k] != code_reg[k]) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        tick_next  = tick_reg;
        err_next   = err_reg;
        entry_next = entry_reg;
        code_next  = code_reg;
        case (func)
            FUNC_TICK: begin
                if (mode_reg == MODE_ENTER || mode_reg == MODE_UNLOCKED) begin
                    tick_next = tick_reg + TICK_STEP;
                end
                if (mode_reg == MODE_ENTER && cnt_reg == CNT_FULL && !err_reg) begin
                    if (match) begin
                        cnt_next  = '0;
                        mode_next = MODE_UNLOCKED;
                    end else begin
                        err_next = 1'b1;
                    end
                    tick_next = '0;
                end
                if (tick_next == timeout_reg) begin
                    if (err_next) begin
                        cnt_next  = '0;
                        mode_next = MODE_IDLE;
                        err_next  = 1'b0;
                    end
                    if (mode_next == MODE_UNLOCKED) begin
                        mode_next = MODE_IDLE;
                        cnt_next  = '0;
                    end
                end
                if (tick_next == TICK_MAX) begin
                    tick_next = '0;
                end
            end
            FUNC_DIGIT: begin
                if ((mode_reg == MODE_ENTER || mode_reg == MODE_CHANGE) &&
                    cnt_reg < CNT_FULL && digit <= DIGIT_MAX) begin
                    for (int k = 0; k < CODE_LEN; k++) begin
                        if (cnt_reg == CNT_W'(k)) begin
                            entry_next[k] = digit;
                        end
                    end
                    cnt_next = cnt_reg + CNT_ONE;
                end
            end
            FUNC_CLEAR: begin
                if ((mode_reg == MODE_ENTER || mode_reg == MODE_CHANGE) && !err_reg) begin
                    cnt_next = '0;
                end
            end
            FUNC_CHANGE: begin
                if (mode_reg == MODE_UNLOCKED) begin
                    mode_next = MODE_CHANGE;
                end else if (mode_reg == MODE_CHANGE && cnt_reg == CNT_FULL) begin
                    code_next = entry_reg;
                    cnt_next  = '0;
                    mode_next = MODE_UNLOCKED;
                    tick_next = '0;
                end
            end
            FUNC_OPEN: begin
                if (mode_reg == MODE_IDLE) begin
                    mode_next = MODE_ENTER;
                end
            end
            default: begin
            end
        endcase
    end

    assign cnt_ext            = {3'b000, cnt_next};
    assign status_next.mode   = mode_next;
    assign status_next.relay  = (mode_next == MODE_UNLOCKED || mode_next == MODE_CHANGE);
    assign status_next.error  = err_next;
    assign status_next.digits = cnt_ext[2:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            cnt_reg  <= '0;
            tick_reg <= '0;
            err_reg  <= 1'b0;
            for (int k = 0; k < CODE_LEN; k++) begin
                entry_reg[k] <= '0;
                code_reg[k]  <= RESET_DIGIT;
            end
        end else if (step_en) begin
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            tick_reg  <= tick_next;
            err_reg   <= err_next;
            entry_reg <= entry_next;
            code_reg  <= code_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            timeout_reg <= cfg_data;
        end
    end

endmodule

// File: design/keypad_code_lock_core.sv
// Keypad code lock top level: input/result handshakes and result register.
// Depends on kcl_pkg, kcl_ctrl and assert_macros.svh.
//
// Use: each input word (s_func, s_digit) is a timer tick or one debounced
// key event: digit, clear, change code or open entry. Every accepted word
// yields exactly one result word: lock_mode, relay_on, error_flag and
// digits_entered, reflecting the state after that word.
// Result: registered, valid in the cycle after accept.
// Throughput: one word per cycle unless a pending result is stalled; the
// state update is one combinational pass from the lock registers into the
// result register. s_ready = !m_valid || m_ready, so a new word is taken in
// the same cycle the pending result is taken. When the receiver stalls, the
// result is held and no further word is accepted until it is taken.
// Config: cfg_data (timeout_ticks) is written whenever cfg_valid is high;
// cfg_ready is always high. Write only while the block is idle.
// Reset (aresetn low, synchronous): idle mode, empty buffer, code 888888,
// timeout 100 ticks, no result pending.
module keypad_code_lock_core #(
    parameter int CODE_LEN = 6
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_func,
    input  logic [3:0] s_digit,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_lock_mode,
    output logic       m_relay_on,
    output logic       m_error_flag,
    output logic [2:0] m_digits_entered,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);
    import kcl_pkg::*;
    `include "assert_macros.svh"

    logic         m_valid_reg;
    lock_status_t result_reg;
    lock_status_t status_next;
    logic         step_en;

    assign s_ready   = !m_valid_reg || m_ready;
    assign step_en   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    kcl_ctrl #(
        .CODE_LEN(CODE_LEN)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .func       (s_func),
        .digit      (s_digit),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .status_next(status_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            result_reg <= status_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_lock_mode      = result_reg.mode;
    assign m_relay_on       = result_reg.relay;
    assign m_error_flag     = result_reg.error;
    assign m_digits_entered = result_reg.digits;

    `KCL_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `KCL_ASSERT(a_accept_gives_result, aclk, aresetn, step_en |=> m_valid, "accepted word lost")
    `KCL_ASSERT(a_relay_mode, aclk, aresetn, m_valid |-> (m_relay_on == (m_lock_mode == MODE_UNLOCKED || m_lock_mode == MODE_CHANGE)), "relay disagrees with mode")
    `KCL_ASSERT(a_error_in_entry, aclk, aresetn, (m_valid && m_error_flag) |-> (m_lock_mode == MODE_ENTER), "error outside entry mode")

endmodule

// File: verif/tb_keypad_code_lock_core.sv
`timescale 1ns / 1ps
// Testbench for keypad_code_lock_core: directed and random key/tick words, each result
// word checked against an in-bench model of the lock. Depends on kcl_pkg and the core.
module tb_keypad_code_lock_core;
    import kcl_pkg::*;

    localparam int         CODE_LEN      = 6;
    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [2:0] s_func    = FUNC_TICK;
    logic [3:0] s_digit   = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [1:0] m_lock_mode;
    logic       m_relay_on;
    logic       m_error_flag;
    logic [2:0] m_digits_entered;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = TIMEOUT_RESET;

    // lock model state
    mode_t                    lk_mode    = MODE_IDLE;
    logic [CODE_LEN-1:0][3:0] lk_entry   = '0;
    logic [CODE_LEN-1:0][3:0] lk_code    = {CODE_LEN{RESET_DIGIT}};
    int                       lk_count   = 0;
    logic [7:0]               lk_ticks   = '0;
    logic                     lk_error   = 1'b0;
    logic [7:0]               lk_timeout = TIMEOUT_RESET;

    lock_status_t pending_status[$];
    int           fail_count  = 0;
    int           cycle_count = 0;
    bit           no_gaps     = 1'b0;
    bit           aim_right   = 1'b0;

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    keypad_code_lock_core #(
        .CODE_LEN(CODE_LEN)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_digit         (s_digit),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_lock_mode     (m_lock_mode),
        .m_relay_on      (m_relay_on),
        .m_error_flag    (m_error_flag),
        .m_digits_entered(m_digits_entered),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    function automatic lock_status_t advance_lock(input logic [2:0] f, input logic [3:0] d);
        lock_status_t st;
        case (f)
            FUNC_TICK: begin
                if (lk_mode == MODE_ENTER || lk_mode == MODE_UNLOCKED)
                    lk_ticks = lk_ticks + TICK_STEP;
                if (lk_mode == MODE_ENTER && lk_count == CODE_LEN && !lk_error) begin
                    if (lk_entry == lk_code) begin
                        lk_count = 0;
                        lk_mode  = MODE_UNLOCKED;
                    end else begin
                        lk_error = 1'b1;
                    end
                    lk_ticks = '0;
                end
                if (lk_ticks == lk_timeout) begin
                    if (lk_error) begin
                        lk_count = 0;
                        lk_mode  = MODE_IDLE;
                        lk_error = 1'b0;
                    end
                    if (lk_mode == MODE_UNLOCKED) begin
                        lk_mode  = MODE_IDLE;
                        lk_count = 0;
                    end
                end
                if (lk_ticks == TICK_MAX)
                    lk_ticks = '0;
            end
            FUNC_DIGIT: begin
                if ((lk_mode == MODE_ENTER || lk_mode == MODE_CHANGE) && lk_count < CODE_LEN
                        && d <= DIGIT_MAX) begin
                    lk_entry[lk_count] = d;
                    lk_count++;
                end
            end
            FUNC_CLEAR: begin
                if ((lk_mode == MODE_ENTER || lk_mode == MODE_CHANGE) && !lk_error)
                    lk_count = 0;
            end
            FUNC_CHANGE: begin
                if (lk_mode == MODE_UNLOCKED) begin
                    lk_mode = MODE_CHANGE;
                end else if (lk_mode == MODE_CHANGE && lk_count == CODE_LEN) begin
                    lk_code  = lk_entry;
                    lk_count = 0;
                    lk_mode  = MODE_UNLOCKED;
                    lk_ticks = '0;
                end
            end
            FUNC_OPEN: begin
                if (lk_mode == MODE_IDLE)
                    lk_mode = MODE_ENTER;
            end
            default: ;
        endcase
        st.mode   = lk_mode;
        st.relay  = (lk_mode == MODE_UNLOCKED || lk_mode == MODE_CHANGE);
        st.error  = lk_error;
        st.digits = lk_count[2:0];
        return st;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic push_event(input logic [2:0] f, input logic [3:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= f;
        s_digit <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_status.push_back(advance_lock(f, d));
    endtask

    task automatic send_code(input logic [CODE_LEN-1:0][3:0] code);
        for (int k = 0; k < CODE_LEN; k++)
            push_event(FUNC_DIGIT, code[k]);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [7:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        lk_timeout = v;
    endtask

    task automatic test_idle_keys();
        push_event(FUNC_TICK, 4'd0);
        push_event(FUNC_CHANGE, 4'd3);
        push_event(FUNC_CLEAR, 4'd0);
        push_event(FUNC_DIGIT, 4'd5);
        push_event(FUNC_SPARE_LO, 4'd15);
        push_event(FUNC_SPARE_HI, 4'd6);
    endtask

    task automatic test_default_code();
        push_event(FUNC_OPEN, 4'd0);
        push_event(FUNC_OPEN, 4'd9);
        send_code({CODE_LEN{RESET_DIGIT}});
        push_event(FUNC_TICK, 4'd0);
    endtask

    // starts unlocked with a one-tick timeout
    task automatic test_change_code();
        push_event(FUNC_CHANGE, 4'd0);
        push_event(FUNC_DIGIT, 4'd0);
        push_event(FUNC_CLEAR, 4'd0);
        push_event(FUNC_DIGIT, 4'd9);
        push_event(FUNC_DIGIT, 4'd0);
        push_event(FUNC_DIGIT, 4'd1);
        push_event(FUNC_DIGIT, 4'd2);
        push_event(FUNC_DIGIT, 4'd3);
        push_event(FUNC_CHANGE, 4'd0);
        push_event(FUNC_DIGIT, 4'd15);
        push_event(FUNC_DIGIT, 4'd4);
        push_event(FUNC_DIGIT, 4'd7);
        push_event(FUNC_TICK, 4'd0);
        push_event(FUNC_CHANGE, 4'd0);
        push_event(FUNC_TICK, 4'd0);
    endtask

    task automatic test_wrong_code();
        push_event(FUNC_OPEN, 4'd0);
        send_code({CODE_LEN{RESET_DIGIT}});
        push_event(FUNC_TICK, 4'd0);
        push_event(FUNC_DIGIT, 4'd5);
        push_event(FUNC_CLEAR, 4'd0);
        push_event(FUNC_TICK, 4'd0);
    endtask

    // partial entry left ticking past the 8-bit counter wrap, then completed
    task automatic test_tick_wrap();
        push_event(FUNC_OPEN, 4'd0);
        push_event(FUNC_DIGIT, lk_code[0]);
        push_event(FUNC_DIGIT, lk_code[1]);
        repeat (300) push_event(FUNC_TICK, 4'($urandom_range(0, 15)));
        for (int k = 2; k < CODE_LEN; k++)
            push_event(FUNC_DIGIT, lk_code[k]);
        push_event(FUNC_TICK, 4'd0);
        push_event(FUNC_TICK, 4'd0);
    endtask

    task automatic test_random_sessions(input int n_words);
        int         r;
        logic [3:0] d;
        for (int n = 0; n < n_words; n++) begin
            r = $urandom_range(0, 99);
            d = ($urandom_range(0, 99) < 8) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
            if (r < 10) begin
                push_event(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
            end else begin
                case (lk_mode)
                    MODE_IDLE: begin
                        aim_right = ($urandom_range(0, 9) < 7);
                        push_event(FUNC_OPEN, 4'($urandom_range(0, 15)));
                    end
                    MODE_ENTER: begin
                        if (lk_count < CODE_LEN && !lk_error) begin
                            if (r < 14)
                                push_event(FUNC_CLEAR, d);
                            else if (aim_right && d <= DIGIT_MAX)
                                push_event(FUNC_DIGIT, lk_code[lk_count]);
                            else
                                push_event(FUNC_DIGIT, d);
                        end else begin
                            push_event(FUNC_TICK, d);
                        end
                    end
                    MODE_UNLOCKED: begin
                        if (r < 40)
                            push_event(FUNC_CHANGE, d);
                        else
                            push_event(FUNC_TICK, d);
                    end
                    default: begin
                        if (lk_count < CODE_LEN)
                            push_event(r < 14 ? FUNC_CLEAR : FUNC_DIGIT, d);
                        else
                            push_event(r < 80 ? FUNC_CHANGE : FUNC_TICK, d);
                    end
                endcase
            end
        end
    endtask

    initial begin : result_sink
        int stall;
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat (1 + $urandom_range(0, 15)) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : check_result
        lock_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                $error("result word with none expected");
                fail_count++;
            end else begin
                want = pending_status.pop_front();
                if (m_lock_mode !== want.mode) begin
                    $error("lock_mode: expected %0d, got %0d", want.mode, m_lock_mode);
                    fail_count++;
                end
                if (m_relay_on !== want.relay) begin
                    $error("relay_on: expected %0d, got %0d", want.relay, m_relay_on);
                    fail_count++;
                end
                if (m_error_flag !== want.error) begin
                    $error("error_flag: expected %0d, got %0d", want.error, m_error_flag);
                    fail_count++;
                end
                if (m_digits_entered !== want.digits) begin
                    $error("digits_entered: expected %0d, got %0d", want.digits,
                           m_digits_entered);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** keypad_code_lock_core: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_keys();
        test_default_code();
        write_timeout(8'd1);
        test_change_code();
        test_wrong_code();
        test_tick_wrap();
        for (int ph = 0; ph < 6; ph++) begin
            no_gaps = (ph % 3 == 2);
            write_timeout(ph == 0 ? 8'd254 : ph == 5 ? 8'd1 : 8'($urandom_range(2, 20)));
            test_random_sessions(70);
        end
        drain_results();
        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("** keypad_code_lock_core: PASSED **");
        else
            $display("** keypad_code_lock_core: FAILED **");
        $finish;
    end

endmodule
